/* rtl/core/bce_pkg.sv */
// ---------------------------------------------------------------------------
// bce_pkg: shared types and constants of the binomial coefficient engine
// Row store geometry, payload widths, sequencer states and the structs that
// pass between the sequencer, the row RAM and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

  // largest n the row store can hold
  localparam int MaxN     = 63;
  localparam int RowDepth = MaxN + 1;
  localparam int AddrW    = $clog2(RowDepth);

  // payload widths
  localparam int IdxW  = 6;
  localparam int CoefW = 60;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CoefW-1:0] coef_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StInit,
    StRow,
    StLoad,
    StAdd,
    StReadK,
    StDataK,
    StDone
  } state_e;

  // row RAM access for one cycle
  typedef struct packed {
    logic  we;
    addr_t waddr;
    coef_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic  valid;
    coef_t coef;
    logic  invalid;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/bce_req_if.sv */
// ---------------------------------------------------------------------------
// bce_req_if: request channel
// Carries one (n, k) request per transaction with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bce_req_if;
  logic                     valid;
  logic                     ready;
  logic [bce_pkg::IdxW-1:0] n_value;
  logic [bce_pkg::IdxW-1:0] k_value;

  modport source (output valid, output n_value, output k_value, input ready);
  modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/bce_rsp_if.sv */
// ---------------------------------------------------------------------------
// bce_rsp_if: result channel
// Carries one coefficient and its invalid flag per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bce_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bce_pkg::CoefW-1:0] coefficient;
  logic                      invalid;

  modport source (output valid, output coefficient, output invalid, input ready);
  modport sink   (input valid, input coefficient, input invalid, output ready);
endinterface

`default_nettype wire

/* rtl/core/bce_row_ram.sv */
// ---------------------------------------------------------------------------
// bce_row_ram: Pascal row store
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bce_row_ram #(
  parameter int Depth = 64,
  parameter int Width = 60,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bce_seq.sv */
// ---------------------------------------------------------------------------
// bce_seq: row update sequencer
// Builds rows 1..n of Pascal's triangle in place in the row RAM, top column
// down to column 1, one column per cycle, then reads back column k.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bce_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request side
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire bce_pkg::idx_t        n_i,
  input  wire bce_pkg::idx_t        k_i,
  // row RAM
  output      bce_pkg::ram_req_t    ram_o,
  input  wire bce_pkg::coef_t       rdata_i,
  // result side
  output      bce_pkg::result_t     res_o,
  input  wire logic                 res_ready_i
);

  bce_pkg::state_e state_q, state_d;
  bce_pkg::idx_t   n_q, n_d, k_q, k_d;
  bce_pkg::idx_t   r_q, r_d, col_q, col_d;
  bce_pkg::coef_t  hi_q, hi_d;
  bce_pkg::coef_t  res_q, res_d;
  logic            inv_q, inv_d;
  bce_pkg::idx_t   top;

  // highest column touched in the current row: min(r, k)
  assign top = (r_q < k_q) ? r_q : k_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bce_pkg::StIdle;
      r_q     <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      col_q   <= col_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    k_q   <= k_d;
    hi_q  <= hi_d;
    res_q <= res_d;
    inv_q <= inv_d;
  end

  // next state, RAM accesses and datapath
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    k_d        = k_q;
    r_d        = r_q;
    col_d      = col_q;
    hi_d       = hi_q;
    res_d      = res_q;
    inv_d      = inv_q;
    in_ready_o = 1'b0;
    ram_o      = '0;
    res_o      = '0;

    case (state_q)
      bce_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d = n_i;
          k_d = k_i;
          r_d = '0;
          if ((k_i > n_i) || (int'(n_i) > bce_pkg::MaxN)) begin
            // rejected request
            res_d   = '0;
            inv_d   = 1'b1;
            state_d = bce_pkg::StDone;
          end else if (k_i == '0) begin
            // C(n,0) = 1, no row work
            res_d   = bce_pkg::coef_t'(1);
            inv_d   = 1'b0;
            state_d = bce_pkg::StDone;
          end else begin
            state_d = bce_pkg::StInit;
          end
        end
      end

      // row 0: only column 0 is live
      bce_pkg::StInit: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = '0;
        ram_o.wdata = bce_pkg::coef_t'(1);
        r_d         = bce_pkg::idx_t'(1);
        state_d     = bce_pkg::StRow;
      end

      // start a row: fetch the top column
      bce_pkg::StRow: begin
        col_d       = top;
        ram_o.re    = 1'b1;
        ram_o.raddr = bce_pkg::addr_t'(top);
        state_d     = bce_pkg::StLoad;
      end

      // hold old row[col], fetch old row[col-1]
      bce_pkg::StLoad: begin
        hi_d        = rdata_i;
        ram_o.re    = 1'b1;
        ram_o.raddr = bce_pkg::addr_t'(bce_pkg::idx_t'(col_q - bce_pkg::idx_t'(1)));
        state_d     = bce_pkg::StAdd;
      end

      // row[col] += row[col-1]; a new diagonal entry is just row[col-1]
      bce_pkg::StAdd: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = bce_pkg::addr_t'(col_q);
        ram_o.wdata = (col_q == r_q) ? rdata_i : bce_pkg::coef_t'(hi_q + rdata_i);
        hi_d        = rdata_i;
        if (col_q == bce_pkg::idx_t'(1)) begin
          if (r_q == n_q) begin
            state_d = bce_pkg::StReadK;
          end else begin
            r_d     = bce_pkg::idx_t'(r_q + bce_pkg::idx_t'(1));
            state_d = bce_pkg::StRow;
          end
        end else begin
          col_d       = bce_pkg::idx_t'(col_q - bce_pkg::idx_t'(1));
          ram_o.re    = 1'b1;
          ram_o.raddr = bce_pkg::addr_t'(bce_pkg::idx_t'(col_q - bce_pkg::idx_t'(2)));
        end
      end

      // read back column k
      bce_pkg::StReadK: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = bce_pkg::addr_t'(k_q);
        state_d     = bce_pkg::StDataK;
      end

      bce_pkg::StDataK: begin
        res_d   = rdata_i;
        inv_d   = 1'b0;
        state_d = bce_pkg::StDone;
      end

      // hand the result to the output register
      bce_pkg::StDone: begin
        res_o.valid   = 1'b1;
        res_o.coef    = res_q;
        res_o.invalid = inv_q;
        if (res_ready_i) begin
          state_d = bce_pkg::StIdle;
        end
      end

      default: begin
        state_d = bce_pkg::StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/binomial_coefficient_engine.sv */
// ---------------------------------------------------------------------------
// binomial_coefficient_engine: C(n, k) by in-place Pascal row updates
// Sequencer plus row RAM; one result per request, held in an output register.
// ---------------------------------------------------------------------------
//  channel | direction | payload                     | transaction
//  --------+-----------+-----------------------------+------------------------
//  req     | in        | n_value[5:0], k_value[5:0]  | valid & ready
//  rsp     | out       | coefficient[59:0], invalid  | valid & ready
//
//  k > n or k = 0: the result is set directly, with no row work.
//  Otherwise rows 1..n are built, columns min(r, k) down to 1 in each row,
//  through the single adder of the column loop.
//  The row RAM needs no clearing: diagonal entries are written before use.
//  A new request is taken once the previous result sits in the output
//  register, even while that result is still stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binomial_coefficient_engine (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bce_req_if.sink   req,
  bce_rsp_if.source rsp
);

  bce_pkg::ram_req_t ram_req;
  bce_pkg::coef_t    ram_rdata;
  bce_pkg::result_t  res;
  logic              res_ready;

  logic              out_valid_q, out_valid_d;
  bce_pkg::coef_t    out_coef_q;
  logic              out_inv_q;

  // sequencer
  bce_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .n_i         (req.n_value),
    .k_i         (req.k_value),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // row store
  bce_row_ram #(
    .Depth (bce_pkg::RowDepth),
    .Width (bce_pkg::CoefW),
    .AddrW (bce_pkg::AddrW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // output register: loads when empty or being drained
  assign res_ready = !out_valid_q || rsp.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_coef_q <= res.coef;
      out_inv_q  <= res.invalid;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.coefficient = out_coef_q;
  assign rsp.invalid     = out_inv_q;

endmodule

`default_nettype wire
